### rtl/core/ttpc_pkg.sv
// ----------------------------------------------------------------------------
// ttpc_pkg
// Shared types, constants and helpers for the degree-sorted row-permutation
// canonical form of a 64-bit set-family word.
// ----------------------------------------------------------------------------
package ttpc_pkg;

  localparam int MAX_ROWS = 6;
  localparam int WORD_W   = 64;
  localparam int ROW_W    = 3;
  localparam int DEG_W    = 6;
  localparam int BYTE_CNT_W = 3;

  typedef logic [MAX_ROWS-1:0][ROW_W-1:0] perm_t;
  typedef logic [MAX_ROWS-1:0][DEG_W-1:0] deg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEGREE,
    S_SEARCH,
    S_DRAIN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic deg_en;
    logic perm_en;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic deg_done;
    logic perm_last;
  } status_t;

  function automatic logic [ROW_W-1:0] rows_in_use(input logic [ROW_W-1:0] cfg);
    logic [ROW_W-1:0] m;
    m = cfg;
    if (cfg == '0) begin
      m = ROW_W'(1);
    end else if (cfg > ROW_W'(MAX_ROWS)) begin
      m = ROW_W'(MAX_ROWS);
    end
    return m;
  endfunction

  function automatic logic [WORD_W-1:0] size_mask(input logic [ROW_W-1:0] m);
    logic [WORD_W-1:0] mask;
    case (m)
      3'd1:    mask = 64'h0000_0000_0000_0003;
      3'd2:    mask = 64'h0000_0000_0000_000F;
      3'd3:    mask = 64'h0000_0000_0000_00FF;
      3'd4:    mask = 64'h0000_0000_0000_FFFF;
      3'd5:    mask = 64'h0000_0000_FFFF_FFFF;
      default: mask = '1;
    endcase
    return mask;
  endfunction

endpackage

### rtl/core/ttpc_ctrl.sv
// ----------------------------------------------------------------------------
// ttpc_ctrl
// Sequencer: accepts an item, runs degree counting and the permutation
// search in the datapath, and hands the result to the output register.
// ----------------------------------------------------------------------------
module ttpc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  ttpc_pkg::status_t status,
  output ttpc_pkg::cmd_t    cmd
);

  ttpc_pkg::state_t state;
  ttpc_pkg::state_t state_next;
  logic             out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ttpc_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      ttpc_pkg::S_IDLE: begin
        in_stall = rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = ttpc_pkg::S_DEGREE;
        end
      end
      ttpc_pkg::S_DEGREE: begin
        cmd.deg_en = 1'b1;
        if (status.deg_done) begin
          state_next = ttpc_pkg::S_SEARCH;
        end
      end
      ttpc_pkg::S_SEARCH: begin
        cmd.perm_en = 1'b1;
        if (status.perm_last) begin
          state_next = ttpc_pkg::S_DRAIN;
        end
      end
      ttpc_pkg::S_DRAIN: begin
        state_next = ttpc_pkg::S_FINISH;
      end
      ttpc_pkg::S_FINISH: begin
        if (!out_valid || !out_stall) begin
          cmd.publish = 1'b1;
          state_next  = ttpc_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ttpc_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid && out_stall;
    if (cmd.publish) begin
      out_valid_next = 1'b1;
    end
  end

`ifndef NO_ASSERTIONS
  a_publish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> !(out_valid && out_stall))
    else $error("result published over a stalled item");

  a_valid_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ttpc_pkg::S_FINISH))
    else $error("result valid raised outside finish");
`endif

endmodule

### rtl/core/ttpc_dp.sv
// ----------------------------------------------------------------------------
// ttpc_dp
// Datapath: family register, per-row degree counters, lexicographic
// permutation stepper, permuted-word stage and running minimum.
// ----------------------------------------------------------------------------
module ttpc_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  ttpc_pkg::cmd_t                cmd,
  input  logic [ttpc_pkg::ROW_W-1:0]    rows,
  input  logic [ttpc_pkg::WORD_W-1:0]   family_bits,
  output ttpc_pkg::status_t             status,
  output logic [ttpc_pkg::WORD_W-1:0]   result
);

  localparam logic [2:0][7:0] LOW_MASK = {8'hF0, 8'hCC, 8'hAA};

  logic [ttpc_pkg::WORD_W-1:0]     fam;
  logic [ttpc_pkg::WORD_W-1:0]     mask;
  logic [ttpc_pkg::BYTE_CNT_W-1:0] cnt;
  ttpc_pkg::deg_t                  deg;
  ttpc_pkg::deg_t                  deg_next;
  ttpc_pkg::perm_t                 perm;
  ttpc_pkg::perm_t                 perm_next;
  ttpc_pkg::perm_t                 sw;
  logic [7:0]                      cur_byte;
  logic [ttpc_pkg::WORD_W-1:0]     cand;
  logic [ttpc_pkg::WORD_W-1:0]     cand_next;
  logic                            cand_ok;
  logic                            cand_ok_next;
  logic                            cand_valid;
  logic [ttpc_pkg::WORD_W-1:0]     best;
  logic                            has_piv;
  logic [ttpc_pkg::ROW_W-1:0]      piv;
  logic [ttpc_pkg::ROW_W-1:0]      pm1;
  logic [ttpc_pkg::ROW_W-1:0]      sw_j;
  logic [ttpc_pkg::ROW_W:0]        ridx;
  logic [ttpc_pkg::MAX_ROWS-1:0]   src;
  logic [ttpc_pkg::MAX_ROWS-1:0]   bv;

  function automatic logic [3:0] popcount8(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int k = 0; k < 8; k++) begin
      n = n + 4'(v[k]);
    end
    return n;
  endfunction

  assign mask     = ttpc_pkg::size_mask(rows);
  assign cur_byte = fam[{cnt, 3'b000} +: 8];

  always_comb begin
    deg_next = deg;
    for (int i = 0; i < 3; i++) begin
      deg_next[i] = deg[i] + ttpc_pkg::DEG_W'(popcount8(cur_byte & LOW_MASK[i]));
    end
    for (int i = 3; i < ttpc_pkg::MAX_ROWS; i++) begin
      if (cnt[i-3]) begin
        deg_next[i] = deg[i] + ttpc_pkg::DEG_W'(popcount8(cur_byte));
      end
    end
  end

  always_comb begin
    has_piv = 1'b0;
    piv     = '0;
    for (int i = 1; i < ttpc_pkg::MAX_ROWS; i++) begin
      if (i < int'(rows) && perm[i-1] < perm[i]) begin
        has_piv = 1'b1;
        piv     = ttpc_pkg::ROW_W'(i);
      end
    end
    pm1  = has_piv ? piv - ttpc_pkg::ROW_W'(1) : '0;
    sw_j = '0;
    for (int j = 0; j < ttpc_pkg::MAX_ROWS; j++) begin
      if (j < int'(rows) && ttpc_pkg::ROW_W'(j) >= piv && perm[j] > perm[pm1]) begin
        sw_j = ttpc_pkg::ROW_W'(j);
      end
    end
    sw       = perm;
    sw[pm1]  = perm[sw_j];
    sw[sw_j] = perm[pm1];
    perm_next = sw;
    ridx      = '0;
    for (int k = 0; k < ttpc_pkg::MAX_ROWS; k++) begin
      if (ttpc_pkg::ROW_W'(k) >= piv && k < int'(rows)) begin
        ridx = (ttpc_pkg::ROW_W+1)'(piv) + (ttpc_pkg::ROW_W+1)'(rows)
             - (ttpc_pkg::ROW_W+1)'(1) - (ttpc_pkg::ROW_W+1)'(k);
        perm_next[k] = sw[ridx[ttpc_pkg::ROW_W-1:0]];
      end
    end
  end

  assign status.perm_last = !has_piv;
  assign status.deg_done  = (cnt == '1);

  always_comb begin
    cand_ok_next = 1'b1;
    for (int i = 1; i < ttpc_pkg::MAX_ROWS; i++) begin
      if (i < int'(rows) && deg[perm[i-1]] > deg[perm[i]]) begin
        cand_ok_next = 1'b0;
      end
    end
  end

  always_comb begin
    cand_next = '0;
    src       = '0;
    bv        = '0;
    for (int b = 0; b < ttpc_pkg::WORD_W; b++) begin
      bv  = ttpc_pkg::MAX_ROWS'(b);
      src = '0;
      for (int j = 0; j < ttpc_pkg::MAX_ROWS; j++) begin
        if (j < int'(rows) && bv[j]) begin
          src[perm[j]] = 1'b1;
        end
      end
      cand_next[b] = fam[src];
    end
    cand_next = cand_next & mask;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cand_valid <= 1'b0;
    end else begin
      cand_valid <= cmd.perm_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best <= '1;
    end else if (cmd.load) begin
      best <= '1;
    end else if (cand_valid && cand_ok && cand < best) begin
      best <= cand;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fam  <= family_bits & mask;
      cnt  <= '0;
      deg  <= '0;
      for (int i = 0; i < ttpc_pkg::MAX_ROWS; i++) begin
        perm[i] <= ttpc_pkg::ROW_W'(i);
      end
    end else begin
      if (cmd.deg_en) begin
        deg <= deg_next;
        cnt <= cnt + ttpc_pkg::BYTE_CNT_W'(1);
      end
      if (cmd.perm_en && has_piv) begin
        perm <= perm_next;
      end
    end
    if (cmd.perm_en) begin
      cand    <= cand_next;
      cand_ok <= cand_ok_next;
    end
    if (cmd.publish) begin
      result <= best;
    end
  end

`ifndef NO_ASSERTIONS
  a_best_monotone: assert property (@(posedge clk) disable iff (rst)
    !cmd.load |=> (best <= $past(best)))
    else $error("running minimum increased");

  a_result_in_range: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.publish) && !$past(rst) |-> ((result & ~mask) == '0))
    else $error("result has bits above the row range");
`endif

endmodule

### rtl/core/truth_table_permutation_canonical.sv
// ----------------------------------------------------------------------------
// truth_table_permutation_canonical
// Canonical form of a 64-bit set-family word under degree-sorted row orders.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with family_bits; an item is taken when
// in_valid is high and in_stall is low. Output channel: out_valid / out_stall
// with canonical_bits, one result per item, in order.
// row_count is written with row_count_write; the user must write it only
// while the block is idle, which the block does not enforce. It sets the
// number of rows m (0 acts as 1, above 6 acts as 6). Per item: degree
// counting (one byte a cycle), then one permutation of the m rows a cycle
// (m! in all, up to 720), then a drain state in which the last candidate
// reaches the running minimum and a finish state that loads the output
// register; one item at a time. The permutation stepper sets the rate.
// The output register lets a new item be taken while a result waits; a
// finished search holds until the receiver frees the output register.
// Reset returns to idle, clears out_valid and sets row_count to 6.
// ----------------------------------------------------------------------------
module truth_table_permutation_canonical (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        row_count_write,
  input  logic [ttpc_pkg::ROW_W-1:0]  row_count,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [ttpc_pkg::WORD_W-1:0] family_bits,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ttpc_pkg::WORD_W-1:0] canonical_bits
);

  logic [ttpc_pkg::ROW_W-1:0] rows_cfg;
  logic [ttpc_pkg::ROW_W-1:0] rows;
  ttpc_pkg::cmd_t             cmd;
  ttpc_pkg::status_t          status;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_cfg <= ttpc_pkg::ROW_W'(ttpc_pkg::MAX_ROWS);
    end else if (row_count_write) begin
      rows_cfg <= row_count;
    end
  end

  assign rows = ttpc_pkg::rows_in_use(rows_cfg);

  ttpc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  ttpc_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .rows        (rows),
    .family_bits (family_bits),
    .status      (status),
    .result      (canonical_bits)
  );

endmodule

### dv/truth_table_permutation_canonical_test.sv
// ----------------------------------------------------------------------------
// truth_table_permutation_canonical_test
// Checks the degree-sorted canonical form of set-family words against an
// in-bench predictor: directed extremes, row_count clamping, masking of bits
// above the row range, then random families over a sweep of row counts with
// random idling on both sides.
// ----------------------------------------------------------------------------
module truth_table_permutation_canonical_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_GAP       = 14;
  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = 800;
  localparam int PENDING_DEPTH = 64;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             row_count_write = 1'b0;
  logic [ttpc_pkg::ROW_W-1:0]       row_count = ttpc_pkg::ROW_W'(ttpc_pkg::MAX_ROWS);
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [ttpc_pkg::WORD_W-1:0]      family_bits = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [ttpc_pkg::WORD_W-1:0]      canonical_bits;

  logic [ttpc_pkg::WORD_W-1:0]      pending_canon [PENDING_DEPTH];
  int                               pending_wr = 0;
  int                               pending_rd = 0;
  logic [ttpc_pkg::ROW_W-1:0]       rows_cfg = ttpc_pkg::ROW_W'(ttpc_pkg::MAX_ROWS);
  int                               mismatch_count = 0;
  int                               idle_cycles = 0;
  int                               stall_left = 0;
  bit                               send_calm = 1'b0;
  bit                               recv_calm = 1'b0;

  truth_table_permutation_canonical uut (
    .clk            (clk),
    .rst            (rst),
    .row_count_write(row_count_write),
    .row_count      (row_count),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .family_bits    (family_bits),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .canonical_bits (canonical_bits)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int rows_of(input logic [ttpc_pkg::ROW_W-1:0] cfg);
    if (cfg == '0) return 1;
    if (cfg > ttpc_pkg::ROW_W'(ttpc_pkg::MAX_ROWS)) return ttpc_pkg::MAX_ROWS;
    return int'(cfg);
  endfunction

  function automatic logic [ttpc_pkg::WORD_W-1:0] canonical_of(
      input logic [ttpc_pkg::WORD_W-1:0] fam,
      input logic [ttpc_pkg::ROW_W-1:0]  cfg);
    int rows, span, perms, rest, pick, f;
    int deg [ttpc_pkg::MAX_ROWS];
    int order [ttpc_pkg::MAX_ROWS];
    int pool [ttpc_pkg::MAX_ROWS];
    logic [ttpc_pkg::WORD_W-1:0] best, word;
    logic [5:0] idx;
    bit ok;
    rows = rows_of(cfg);
    span = 1 << rows;
    if (span < ttpc_pkg::WORD_W) fam &= (64'd1 << span) - 64'd1;
    for (int r = 0; r < ttpc_pkg::MAX_ROWS; r++) deg[r] = 0;
    for (int a = 0; a < span; a++)
      if (fam[a])
        for (int r = 0; r < rows; r++) deg[r] += (a >> r) & 1;
    perms = 1;
    for (int r = 2; r <= rows; r++) perms *= r;
    best = '1;
    for (int k = 0; k < perms; k++) begin
      for (int r = 0; r < rows; r++) pool[r] = r;
      rest = k;
      f = perms;
      for (int p = 0; p < rows; p++) begin
        f = f / (rows - p);
        pick = rest / f;
        rest = rest % f;
        order[p] = pool[pick];
        for (int q = pick; q < rows - 1 - p; q++) pool[q] = pool[q + 1];
      end
      ok = 1'b1;
      for (int p = 1; p < rows; p++)
        if (deg[order[p - 1]] > deg[order[p]]) ok = 1'b0;
      if (ok) begin
        word = '0;
        for (int a = 0; a < span; a++) begin
          if (fam[a]) begin
            idx = '0;
            for (int j = 0; j < rows; j++)
              if (((a >> order[j]) & 1) != 0) idx[j] = 1'b1;
            word[idx] = 1'b1;
          end
        end
        if (word < best) best = word;
      end
    end
    return best;
  endfunction

  function automatic logic [ttpc_pkg::WORD_W-1:0] random_family(input int rows);
    logic [ttpc_pkg::WORD_W-1:0] fam, in_range;
    logic [ttpc_pkg::MAX_ROWS:0] weights;
    int span;
    span = 1 << rows;
    in_range = (span < ttpc_pkg::WORD_W) ? (64'd1 << span) - 64'd1 : '1;
    case ($urandom_range(0, 3))
      0: fam = {$urandom, $urandom};
      1: begin
        fam = '0;
        repeat ($urandom_range(1, 4)) fam[$urandom_range(0, span - 1)] = 1'b1;
      end
      2: begin
        fam = '1;
        repeat ($urandom_range(1, 4)) fam[$urandom_range(0, span - 1)] = 1'b0;
      end
      default: begin
        fam = '0;
        weights = (ttpc_pkg::MAX_ROWS + 1)'($urandom_range(0, 127));
        for (int a = 0; a < span; a++)
          if (weights[$countones(a)]) fam[a] = 1'b1;
      end
    endcase
    if ($urandom_range(0, 2) == 0) fam |= {$urandom, $urandom} & ~in_range;
    return fam;
  endfunction

  task automatic note_mismatch(input logic [ttpc_pkg::WORD_W-1:0] want, input string what);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s: expected %h, got %h", $realtime, what, want, canonical_bits);
  endtask

  always @(posedge clk) begin : monitor
    logic [ttpc_pkg::WORD_W-1:0] want;
    if (rst) begin
      rows_cfg = ttpc_pkg::ROW_W'(ttpc_pkg::MAX_ROWS);
      idle_cycles = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_wr == pending_rd) begin
          note_mismatch('x, "unexpected result");
        end else begin
          want = pending_canon[pending_rd % PENDING_DEPTH];
          pending_rd++;
          if (canonical_bits !== want) note_mismatch(want, "canonical_bits mismatch");
        end
      end
      if (in_valid && !in_stall) begin
        pending_canon[pending_wr % PENDING_DEPTH] = canonical_of(family_bits, rows_cfg);
        pending_wr++;
      end
      if (row_count_write) rows_cfg = row_count;
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("truth_table_permutation_canonical test failed");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      stall_left = $urandom_range(0, MAX_GAP);
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if ($urandom_range(0, 15) == 0) recv_calm = !recv_calm;
        stall_left = recv_calm ? 0 : $urandom_range(0, MAX_GAP);
      end else if (out_valid && stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left > 0);
    end
  end

  task automatic send_family(input logic [ttpc_pkg::WORD_W-1:0] fam);
    int gap;
    if ($urandom_range(0, 15) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    family_bits <= fam;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_for_results;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_wr != pending_rd) @(posedge clk);
  endtask

  task automatic write_row_count(input logic [ttpc_pkg::ROW_W-1:0] value);
    wait_for_results();
    repeat (2) @(posedge clk);
    row_count_write <= 1'b1;
    row_count <= value;
    @(posedge clk);
    row_count_write <= 1'b0;
  endtask

  task automatic test_extremes;
    send_family(64'h0);
    send_family('1);
    send_family(64'h1);
    send_family(64'h8000_0000_0000_0000);
    send_family(64'hAAAA_AAAA_AAAA_AAAA);
    send_family(64'h5555_5555_5555_5555);
    send_family(64'h8000_0000_0000_0001);
    send_family(64'h0123_4567_89AB_CDEF);
    send_family(64'hFEDC_BA98_7654_3210);
  endtask

  task automatic test_row_count_clamp;
    write_row_count(ttpc_pkg::ROW_W'(0));
    send_family(64'h0);
    send_family(64'h1);
    send_family(64'h2);
    send_family(64'hFFFF_FFFF_FFFF_FFFC);
    send_family('1);
    write_row_count(ttpc_pkg::ROW_W'(7));
    send_family('1);
    send_family(64'h8000_0000_0000_0001);
    send_family(64'h0000_0000_0000_0116);
  endtask

  task automatic test_high_bits_ignored;
    write_row_count(ttpc_pkg::ROW_W'(3));
    send_family(64'hFFFF_FFFF_FFFF_FF00);
    send_family(64'hDEAD_BEEF_0000_0017);
    send_family(64'hA5A5_A5A5_A5A5_A5E8);
    write_row_count(ttpc_pkg::ROW_W'(5));
    send_family(64'h1234_5678_0000_0001);
  endtask

  task automatic test_random_sweep;
    logic [ttpc_pkg::ROW_W-1:0] cfgs [8] = '{3'd3, 3'd1, 3'd5, 3'd0, 3'd4, 3'd2, 3'd7, 3'd6};
    int counts [8] = '{150, 80, 150, 60, 150, 120, 40, 60};
    for (int s = 0; s < 8; s++) begin
      write_row_count(cfgs[s]);
      for (int n = 0; n < counts[s]; n++) begin
        send_family(random_family(rows_of(cfgs[s])));
        if ($urandom_range(0, 39) == 0) wait_for_results();
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_extremes();
    test_row_count_clamp();
    test_high_bits_ignored();
    test_random_sweep();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_wr == pending_rd) begin
      $display("truth_table_permutation_canonical test passed");
    end else begin
      $display("truth_table_permutation_canonical test failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/ttpc_pkg.sv
rtl/core/ttpc_ctrl.sv
rtl/core/ttpc_dp.sv
rtl/core/truth_table_permutation_canonical.sv
dv/truth_table_permutation_canonical_test.sv
